// ----- src/multi_channel_interval_timer_core_assert.svh -----
// Assertion macros for the interval timer core.
`ifndef MULTI_CHANNEL_INTERVAL_TIMER_CORE_ASSERT_SVH
`define MULTI_CHANNEL_INTERVAL_TIMER_CORE_ASSERT_SVH
`ifndef SYNTH
`define MCIT_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define MCIT_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define MCIT_ASSERT_IMPL(label, clk, rst, prop)
`define MCIT_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ----- src/mcit_pkg.sv -----
// Package: shared types, codes and command/status structs for the interval timer.
`timescale 1ns / 1ps
`default_nettype none
package mcit_pkg;
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_MODIFY = 2'd1;
  localparam logic [1:0] MODE_KILL   = 2'd2;
  localparam logic [1:0] MODE_TICK   = 2'd3;

  localparam logic [1:0] KIND_CREATED = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_FIRED   = 2'd2;
  localparam logic [1:0] KIND_TICK    = 2'd3;

  localparam int FIRE_LIMIT = 56;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  slot;
    logic [15:0] period;
    logic        repeat_req;
    logic [2:0]  step;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] which_slot;
    logic       status;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_EMIT, ST_WAIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item
    logic do_cmd;     // execute create/modify/kill
    logic scan_start; // clear search result
    logic scan_step;  // examine one slot
    logic fire;       // fire best, advance time
    logic finish;     // spend remaining step
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       is_tick;
    logic       scan_done;
    logic       fire_ok;   // best exists and due within remaining step
  } stat_t;
endpackage
`default_nettype wire

// ----- src/multi_channel_interval_timer_core.sv -----
// Top level of the multi-channel interval timer core.
// Usage:
//  - Input channel (in_valid/in_stall/in_data) carries one transaction per
//    create, modify, kill or tick command.
//  - Output channel (out_valid/out_stall/out_data) returns results; the last
//    result of each command has last = 1.
//  - Create/modify/kill: the result is registered in ST_DECIDE, the state
//    after accept. Tick: the search examines one slot per cycle; after
//    accept and after each fire, ST_DECIDE, ST_SCAN and ST_EMIT give a fired
//    result while a timer is due, and ST_WAIT then gives the tick-done result
//    (entered straight from ST_DECIDE once 56 fires have occurred).
//  - One command is processed at a time; in_stall is low only when idle.
//  - The output register holds a result while out_stall is high; the
//    controller pauses before producing the next result.
//  - Reset (rst, synchronous) frees all slots and empties the output.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_channel_interval_timer_core_assert.svh"
module multi_channel_interval_timer_core import mcit_pkg::*; #(
  parameter int TIMERS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  cmd_t      cmd;
  stat_t     stat;
  out_item_t cmd_res;
  logic [2:0] best_slot;

  mcit_datapath #(.TIMERS(TIMERS)) u_dp (
    .clk, .rst, .item(in_data), .cmd, .stat, .cmd_res, .best_slot
  );

  mcit_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd_res, .best_slot, .cmd, .res(out_data)
  );

  // stalled result holds; at most one command strobe per cycle
  `MCIT_ASSERT_IMPL(a_hold, clk, rst, (out_valid && out_stall) |=> out_valid && $stable(out_data))
  `MCIT_ASSERT_IMPL(a_one, clk, rst, $onehot0({cmd.load, cmd.do_cmd, cmd.fire, cmd.finish}))
endmodule
`default_nettype wire

// ----- src/mcit_datapath.sv -----
// Datapath: slot table, earliest-timer search and result formation.
`timescale 1ns / 1ps
`default_nettype none
module mcit_datapath import mcit_pkg::*; #(
  parameter int TIMERS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire in_item_t  item,
  input  wire cmd_t      cmd,
  output stat_t          stat,
  output out_item_t      cmd_res,
  output logic [2:0]     best_slot
);
  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  logic [TIMERS-1:0] active;
  logic [15:0] per  [TIMERS];
  logic        rep  [TIMERS];
  logic [15:0] ela  [TIMERS];
  logic [2:0]  rank [TIMERS];

  in_item_t    cur;
  logic [3:0]  s_left;
  logic [IW:0] scan_i;
  logic        bvalid;
  logic [IW-1:0] bidx;
  logic [15:0] brem;
  logic [2:0]  brank;

  logic [IW-1:0] si;
  logic [15:0]   r_i;
  assign si  = scan_i[IW-1:0];
  assign r_i = (ela[si] >= per[si]) ? 16'd0 : per[si] - ela[si];

  // free-slot search and active-slot count
  logic          have_free;
  logic [IW-1:0] free_idx;
  logic [3:0]    cnt;
  always_comb begin
    have_free = 1'b0;
    free_idx  = '0;
    cnt       = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (active[i]) cnt = cnt + 4'd1;
      else begin
        have_free = 1'b1;
        free_idx  = IW'(i);
      end
    end
  end

  logic slot_ok;
  assign slot_ok = (32'(cur.slot) < TIMERS) && active[cur.slot[IW-1:0]];

  logic [15:0] fixp;
  assign fixp = (cur.period == 16'd0) ? 16'd1 : cur.period;

  always_comb begin
    cmd_res = '0;
    cmd_res.last = 1'b1;
    case (cur.mode)
      MODE_CREATE: begin
        cmd_res.kind = KIND_CREATED;
        cmd_res.which_slot = have_free ? 3'(free_idx) : 3'd0;
        cmd_res.status = !have_free;
      end
      default: begin
        cmd_res.kind = KIND_DONE;
        cmd_res.which_slot = cur.slot;
        cmd_res.status = !slot_ok;
      end
    endcase
  end

  assign stat.is_tick   = (cur.mode == MODE_TICK);
  assign stat.scan_done = (32'(scan_i) >= TIMERS);
  assign stat.fire_ok   = bvalid && ({1'b0, brem} <= 17'(s_left));
  assign best_slot      = 3'(bidx);

  logic [15:0] d;
  assign d = cmd.fire ? brem : 16'(s_left);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur    <= item;
      s_left <= {1'b0, item.step};
    end
    if (cmd.scan_start) begin
      scan_i <= '0;
      bvalid <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_i <= scan_i + 1'b1;
      if (active[si] && (!bvalid || r_i < brem || (r_i == brem && rank[si] < brank))) begin
        bvalid <= 1'b1;
        bidx   <= si;
        brem   <= r_i;
        brank  <= rank[si];
      end
    end
    if (cmd.fire || cmd.finish) begin
      // a repeating timer that fires restarts; every other active one ages
      for (int i = 0; i < TIMERS; i++) begin
        if (active[i]) begin
          if (cmd.fire && rep[bidx] && IW'(i) == bidx) ela[i] <= '0;
          else ela[i] <= (17'(ela[i]) + 17'(d) > 17'd65535) ? 16'hFFFF
                         : ela[i] + d;
        end
      end
      if (cmd.fire) begin
        s_left <= s_left - brem[3:0];
        if (!rep[bidx])
          for (int i = 0; i < TIMERS; i++)
            if (active[i] && rank[i] > brank) rank[i] <= rank[i] - 3'd1;
      end
    end
    if (cmd.do_cmd) begin
      if (cur.mode == MODE_CREATE && have_free) begin
        per[free_idx]  <= fixp;
        rep[free_idx]  <= cur.repeat_req;
        ela[free_idx]  <= '0;
        rank[free_idx] <= cnt[2:0];
      end else if (cur.mode == MODE_MODIFY && slot_ok) begin
        per[cur.slot[IW-1:0]] <= fixp;
        rep[cur.slot[IW-1:0]] <= cur.repeat_req;
      end else if (cur.mode == MODE_KILL && slot_ok) begin
        for (int i = 0; i < TIMERS; i++)
          if (active[i] && rank[i] > rank[cur.slot[IW-1:0]]) rank[i] <= rank[i] - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) active <= '0;
    else if (cmd.do_cmd) begin
      if (cur.mode == MODE_CREATE && have_free) active[free_idx] <= 1'b1;
      else if (cur.mode == MODE_KILL && slot_ok) active[cur.slot[IW-1:0]] <= 1'b0;
    end else if (cmd.fire && !rep[bidx]) active[bidx] <= 1'b0;
  end
endmodule
`default_nettype wire

// ----- src/mcit_ctrl.sv -----
// Controller: sequences commands, the per-fire search and the output register.
`timescale 1ns / 1ps
`default_nettype none
module mcit_ctrl import mcit_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire stat_t     stat,
  input  wire out_item_t cmd_res,
  input  wire logic [2:0] best_slot,
  output cmd_t           cmd,
  output out_item_t      res
);
  state_t state, state_next;
  logic [5:0] nfire;
  logic ov, ov_next, ld;
  out_item_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      nfire <= '0;
    end else begin
      state <= state_next;
      out_valid <= ov_next;
      if (cmd.load) nfire <= '0;
      else if (cmd.fire) nfire <= nfire + 6'd1;
    end
    if (ld) res <= res_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    ld = 1'b0;
    res_next = cmd_res;
    ov = out_valid && out_stall;   // result still held
    ov_next = ov;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!stat.is_tick) begin
          if (!ov) begin
            cmd.do_cmd = 1'b1;
            ld = 1'b1;
            ov_next = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (32'(nfire) >= FIRE_LIMIT) begin
          state_next = ST_WAIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) state_next = ST_EMIT;
        else cmd.scan_step = 1'b1;
      end
      ST_EMIT: begin
        if (!stat.fire_ok) state_next = ST_WAIT;
        else if (!ov) begin
          cmd.fire = 1'b1;
          ld = 1'b1;
          res_next = '{kind: KIND_FIRED, which_slot: best_slot, status: 1'b0, last: 1'b0};
          ov_next = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_WAIT: begin
        if (!ov) begin
          cmd.finish = 1'b1;
          ld = 1'b1;
          res_next = '{kind: KIND_TICK, which_slot: 3'd0, status: 1'b0, last: 1'b1};
          ov_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire
